FILE: src/cln_pkg.sv
// Shared types, constants and the init byte table for the 4-bit LCD writer.
package cln_pkg;

   localparam int BYTE_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int OPCODE_W    = 2;
   localparam int WAIT_W      = 18;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;
   localparam int RSP_W       = 8;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_HIGH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_LOW   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_SETTLE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_STEP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_SETTLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_ON     = 3'd5;

   // configuration reset values
   localparam logic [7:0]  RST_ENABLE_HIGH  = 8'd1;
   localparam logic [7:0]  RST_ENABLE_LOW   = 8'd1;
   localparam logic [11:0] RST_BYTE_SETTLE  = 12'd50;
   localparam logic [11:0] RST_INIT_STEP    = 12'd100;
   localparam logic [15:0] RST_CLEAR_SETTLE = 16'd5000;
   localparam logic [17:0] RST_POWER_ON     = 18'd100000;

   localparam logic [NIBBLE_W-1:0] INIT_NIBBLE = 4'h3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK    = 2'd0,
      OP_COMMAND = 2'd1,
      OP_DATA    = 2'd2,
      OP_INIT    = 2'd3
   } op_type;

   // classified request as it sits in the queue
   typedef struct packed {
      op_type            op;
      logic              select;
      logic [BYTE_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // packed so that rs_line lands in bit 0 of the response beat
   typedef struct packed {
      logic                accepted;
      logic                busy;
      logic [NIBBLE_W-1:0] nibble;
      logic                enable;
      logic                rs;
   } result_type;

   function automatic logic [BYTE_W-1:0] init_byte(input logic [2:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0:    b = 8'h2C;   // function set
         3'd1:    b = 8'h2C;   // function set again
         3'd2:    b = 8'h0F;   // display on, cursor and blink
         3'd3:    b = 8'h01;   // clear
         3'd4:    b = 8'h06;   // entry mode
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: src/cln_front.sv
// Request front end: takes request beats and classifies them for the queue.
module cln_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cln_pkg::BYTE_W-1:0]    req_tdata,
   input  logic [cln_pkg::OPCODE_W-1:0]  req_tuser,
   input  logic                          queue_full,
   output logic                          push_valid,
   output cln_pkg::item_type             push_item
);
   import cln_pkg::*;

   op_type op;

   assign op         = op_type'(req_tuser);
   assign req_tready = !queue_full;
   assign push_valid = req_tvalid && !queue_full;

   always_comb begin
      push_item.op     = op;
      push_item.select = 1'b0;
      push_item.value  = '0;
      unique case (op)
         OP_COMMAND: begin
            push_item.value = req_tdata;
         end
         OP_DATA: begin
            push_item.select = 1'b1;
            push_item.value  = req_tdata;
         end
         OP_TICK, OP_INIT: begin
            // byte is don't-care for these
            push_item.value = '0;
         end
         default: begin
            push_item.value = '0;
         end
      endcase
   end

endmodule

FILE: src/cln_queue.sv
// Short request queue between the front end and the sequencer.
module cln_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cln_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output cln_pkg::item_type pop_item,
   output logic              empty
);
   import cln_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) n = '0;
      else                                n = p + 1'b1;
      return n;
   endfunction

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/cln_back.sv
// Sequencer: runs nibble strobes, waits and the init sequence; holds the response beat.
module cln_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cln_pkg::csr_write_type        csr_wr,
   input  logic                          queue_empty,
   input  cln_pkg::item_type             item,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cln_pkg::RSP_W-1:0]     rsp_tdata
);
   import cln_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_POWER  = 3'd1,
      PH_HIGH   = 3'd2,
      PH_LOW    = 3'd3,
      PH_SETTLE = 3'd4
   } phase_type;

   localparam logic [2:0] POS_NONE       = 3'd0;
   localparam logic [2:0] POS_POWER      = 3'd1;
   localparam logic [2:0] POS_NIBBLE     = 3'd2;
   localparam logic [2:0] POS_FIRST_BYTE = 3'd3;
   localparam logic [2:0] POS_CLEAR_BYTE = 3'd6;
   localparam logic [2:0] POS_LAST_BYTE  = 3'd7;

   // configuration
   logic [7:0]  enable_high_ff, enable_low_ff;
   logic [11:0] byte_settle_ff, init_step_ff;
   logic [15:0] clear_settle_ff;
   logic [17:0] power_on_ff;

   // sequencer state
   phase_type           phase_ff, phase_in;
   logic [2:0]          position_ff, position_in;
   logic [WAIT_W-1:0]   wait_ff, wait_in;
   logic [BYTE_W-1:0]   held_ff, held_in;
   logic                pending_ff, pending_in;
   logic                select_ff, select_in;
   logic                strobe_ff, strobe_in;
   logic [NIBBLE_W-1:0] nibble_ff, nibble_in;

   logic                rsp_valid_ff;
   result_type          rsp_ff, rsp_in;

   logic                busy;
   logic                accepted;
   logic [WAIT_W-1:0]   settle_wait;
   logic [BYTE_W-1:0]   next_init_byte;

   assign busy = (phase_ff != PH_IDLE);
   assign pop  = !queue_empty && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      case (position_ff)
         POS_NONE, POS_LAST_BYTE: settle_wait = WAIT_W'(byte_settle_ff);
         POS_CLEAR_BYTE:          settle_wait = WAIT_W'(clear_settle_ff);
         default:                 settle_wait = WAIT_W'(init_step_ff);
      endcase
   end

   assign next_init_byte = init_byte(position_ff + 1'b1 - POS_FIRST_BYTE);

   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      wait_in     = wait_ff;
      held_in     = held_ff;
      pending_in  = pending_ff;
      select_in   = select_ff;
      strobe_in   = strobe_ff;
      nibble_in   = nibble_ff;
      accepted    = 1'b0;

      if (item.op == OP_TICK) begin
         if (busy) begin
            if (wait_ff <= WAIT_W'(1)) begin
               unique case (phase_ff)
                  PH_POWER: begin
                     position_in = POS_NIBBLE;
                     pending_in  = 1'b0;
                     select_in   = 1'b0;
                     nibble_in   = INIT_NIBBLE;
                     strobe_in   = 1'b1;
                     phase_in    = PH_HIGH;
                     wait_in     = WAIT_W'(enable_high_ff);
                  end
                  PH_HIGH: begin
                     strobe_in = 1'b0;
                     phase_in  = PH_LOW;
                     wait_in   = WAIT_W'(enable_low_ff);
                  end
                  PH_LOW: begin
                     if (pending_ff) begin
                        pending_in = 1'b0;
                        nibble_in  = held_ff[3:0];
                        strobe_in  = 1'b1;
                        phase_in   = PH_HIGH;
                        wait_in    = WAIT_W'(enable_high_ff);
                     end else begin
                        phase_in = PH_SETTLE;
                        wait_in  = settle_wait;
                     end
                  end
                  PH_SETTLE: begin
                     if (position_ff >= POS_NIBBLE && position_ff < POS_LAST_BYTE) begin
                        position_in = position_ff + 1'b1;
                        held_in     = next_init_byte;
                        select_in   = 1'b0;
                        pending_in  = 1'b1;
                        nibble_in   = next_init_byte[7:4];
                        strobe_in   = 1'b1;
                        phase_in    = PH_HIGH;
                        wait_in     = WAIT_W'(enable_high_ff);
                     end else begin
                        position_in = POS_NONE;
                        phase_in    = PH_IDLE;
                        wait_in     = '0;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
      end else if (!busy) begin
         accepted = 1'b1;
         if (item.op == OP_INIT) begin
            select_in   = 1'b0;
            strobe_in   = 1'b0;
            nibble_in   = '0;
            pending_in  = 1'b0;
            position_in = POS_POWER;
            phase_in    = PH_POWER;
            wait_in     = power_on_ff;
         end else begin
            position_in = POS_NONE;
            held_in     = item.value;
            select_in   = item.select;
            pending_in  = 1'b1;
            nibble_in   = item.value[7:4];
            strobe_in   = 1'b1;
            phase_in    = PH_HIGH;
            wait_in     = WAIT_W'(enable_high_ff);
         end
      end

      rsp_in.accepted = accepted;
      rsp_in.busy     = (phase_in != PH_IDLE);
      rsp_in.nibble   = nibble_in;
      rsp_in.enable   = strobe_in;
      rsp_in.rs       = select_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         position_ff  <= POS_NONE;
         wait_ff      <= '0;
         held_ff      <= '0;
         pending_ff   <= 1'b0;
         select_ff    <= 1'b0;
         strobe_ff    <= 1'b0;
         nibble_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff    <= phase_in;
            position_ff <= position_in;
            wait_ff     <= wait_in;
            held_ff     <= held_in;
            pending_ff  <= pending_in;
            select_ff   <= select_in;
            strobe_ff   <= strobe_in;
            nibble_ff   <= nibble_in;
         end
         if (pop)             rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_high_ff  <= RST_ENABLE_HIGH;
         enable_low_ff   <= RST_ENABLE_LOW;
         byte_settle_ff  <= RST_BYTE_SETTLE;
         init_step_ff    <= RST_INIT_STEP;
         clear_settle_ff <= RST_CLEAR_SETTLE;
         power_on_ff     <= RST_POWER_ON;
      end else if (csr_wr.valid) begin
         case (csr_wr.index)
            CSR_ENABLE_HIGH:  enable_high_ff  <= csr_wr.data[7:0];
            CSR_ENABLE_LOW:   enable_low_ff   <= csr_wr.data[7:0];
            CSR_BYTE_SETTLE:  byte_settle_ff  <= csr_wr.data[11:0];
            CSR_INIT_STEP:    init_step_ff    <= csr_wr.data[11:0];
            CSR_CLEAR_SETTLE: clear_settle_ff <= csr_wr.data[15:0];
            CSR_POWER_ON:     power_on_ff     <= csr_wr.data[17:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // a request that meets a busy sequencer is refused
   a_refused_when_busy: assert property (@(posedge clock) disable iff (reset)
      pop && busy |=> !rsp_ff.accepted)
      else $error("request accepted while busy");

   // enable only stands high during the strobe phase
   a_strobe_in_high: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> phase_ff == PH_HIGH)
      else $error("enable high outside strobe phase");

   // second nibble is only owed while a byte is on the bus
   a_pending_in_byte: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (phase_ff == PH_HIGH || phase_ff == PH_LOW))
      else $error("low nibble pending outside a byte");

   // init sequence position only lives while busy
   a_position_busy: assert property (@(posedge clock) disable iff (reset)
      position_ff != POS_NONE |-> busy)
      else $error("init position set while idle");

endmodule

FILE: src/char_lcd_nibble_writer.sv
// Top level of the 4-bit character LCD writer: front end, queue and sequencer.
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     tdata: byte_value; tuser: opcode
//  rsp      out  rsp_tvalid/tready     tdata: rs, enable, nibble, busy, accepted
//  csr      in   csr_valid/csr_ready   csr_index, csr_data
//
//  One request beat in, one response beat out, sustained at one beat per clock
//  while the response is not stalled. A beat passes through the request queue,
//  then the response register. The sequencer state update (one wait-counter
//  compare and decrement) sets that rate. Reset is synchronous, active high, and
//  restores the register defaults. A stalled response backs the queue up and only
//  then drops req_tready. csr_ready is always high.
module char_lcd_nibble_writer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cln_pkg::BYTE_W-1:0]       req_tdata,   // [7:0] byte_value
   input  logic [cln_pkg::OPCODE_W-1:0]     req_tuser,   // [1:0] opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] rs_line, [1] enable_line, [5:2] bus_nibble, [6] busy_res, [7] accepted
   output logic [cln_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cln_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cln_pkg::CSR_DATA_W-1:0]   csr_data
);
   import cln_pkg::*;

   logic          queue_full;
   logic          queue_empty;
   logic          push_valid;
   item_type      push_item;
   item_type      head_item;
   logic          pop;
   csr_write_type csr_wr;

   // register writes never stall
   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   cln_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // decouples request intake from response backpressure
   cln_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (head_item),
      .empty     (queue_empty)
   );

   // one queued beat per clock whenever the response register can take it
   cln_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr      (csr_wr),
      .queue_empty (queue_empty),
      .item        (head_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
